/* rtl/prime_count_sieve_macros.svh */
// Assertion macros shared by the prime count sieve RTL.
`ifndef PRIME_COUNT_SIEVE_MACROS_SVH
`define PRIME_COUNT_SIEVE_MACROS_SVH

// Same-cycle implication, checked on clk and held off during reset.
`define PCS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and held off during reset.
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pcs_pkg.sv */
// Package: sizes, controller states and command/status types of the prime count sieve.
package pcs_pkg;

	localparam int MAX_LIMIT   = 16384;
	localparam int ADDR_W      = $clog2(MAX_LIMIT);
	localparam int N_W         = 15;
	localparam int P_W         = 8;
	localparam int CNT_W       = 11;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	localparam logic [N_W-1:0]   LIMIT_SAT = N_W'(MAX_LIMIT);
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_P_TEST,
		ST_P_WAIT,
		ST_MARK,
		ST_COUNT,
		ST_DONE
	} pcs_state_t;

	typedef struct packed {
		logic load;        // take a new limit, restart all counters
		logic clr_wr;      // clear mark at k, step k
		logic p_rd;        // read mark at p
		logic p_next;      // advance p and p squared
		logic mark_start;  // k gets p squared
		logic mark_wr;     // set mark at k, step k by p
		logic cnt_start;   // k gets 2
		logic cnt_rd;      // read mark at k for counting, step k
		logic out_load;    // move count into the output register
	} pcs_cmd_t;

	typedef struct packed {
		logic k_lt_n;      // k below limit
		logic psq_lt_n;    // p squared below limit
		logic p_comp;      // mark read for p says composite
		logic out_free;    // output register can take a result
	} pcs_sts_t;

endpackage

/* rtl/pcs_ctrl.sv */
// Controller state machine: clear, sieve and count phases of one request.
module pcs_ctrl
	import pcs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pcs_sts_t sts,
	output pcs_cmd_t cmd
);

	pcs_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_nxt = ST_CLEAR;
			ST_CLEAR:  if (!sts.k_lt_n) state_nxt = ST_P_TEST;
			ST_P_TEST: state_nxt = sts.psq_lt_n ? ST_P_WAIT : ST_COUNT;
			ST_P_WAIT: state_nxt = sts.p_comp ? ST_P_TEST : ST_MARK;
			ST_MARK:   if (!sts.k_lt_n) state_nxt = ST_P_TEST;
			ST_COUNT:  if (!sts.k_lt_n) state_nxt = ST_DONE;
			ST_DONE:   if (sts.out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CLEAR: begin
				cmd.clr_wr = sts.k_lt_n;
			end
			ST_P_TEST: begin
				cmd.p_rd      = sts.psq_lt_n;
				cmd.cnt_start = !sts.psq_lt_n;
			end
			ST_P_WAIT: begin
				cmd.p_next     = sts.p_comp;
				cmd.mark_start = !sts.p_comp;
			end
			ST_MARK: begin
				cmd.mark_wr = sts.k_lt_n;
				cmd.p_next  = !sts.k_lt_n;
			end
			ST_COUNT: begin
				cmd.cnt_rd = sts.k_lt_n;
			end
			ST_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* rtl/pcs_dp.sv */
// Datapath: mark memory, index counters, prime counter and output register.
module pcs_dp
	import pcs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [N_W-1:0]         limit,
	input  pcs_cmd_t               cmd,
	output pcs_sts_t               sts,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CNT_W-1:0]       prime_count
);

	logic                 mark_mem [MAX_LIMIT];
	logic [N_W-1:0]       n_q;
	logic [N_W-1:0]       k_q;
	logic [P_W-1:0]       p_q;
	logic [N_W-1:0]       psq_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     prime_count_q;
	logic                 out_valid_q;
	logic                 rd_q;
	logic                 rd_vld_s1;
	logic [ADDR_W-1:0]    raddr;

	assign raddr = cmd.p_rd ? ADDR_W'(p_q) : k_q[ADDR_W-1:0];

	// single-bit store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clr_wr || cmd.mark_wr) begin
			mark_mem[k_q[ADDR_W-1:0]] <= cmd.mark_wr;
		end
		rd_q <= mark_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q     <= (limit > LIMIT_SAT) ? LIMIT_SAT : limit;
			k_q     <= '0;
			p_q     <= P_W'(2);
			psq_q   <= N_W'(4);
			count_q <= '0;
		end else begin
			if (cmd.clr_wr || cmd.cnt_rd) begin
				k_q <= k_q + N_W'(1);
			end else if (cmd.mark_wr) begin
				k_q <= k_q + N_W'(p_q);
			end else if (cmd.mark_start) begin
				k_q <= psq_q;
			end else if (cmd.cnt_start) begin
				k_q <= N_W'(2);
			end
			if (cmd.p_next) begin
				// (p+1)^2 = p^2 + 2p + 1
				p_q   <= p_q + P_W'(1);
				psq_q <= psq_q + N_W'({p_q, 1'b0}) + N_W'(1);
			end
			if (rd_vld_s1 && !rd_q && count_q != COUNT_MAX) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
		if (cmd.out_load) begin
			prime_count_q <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.cnt_rd;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.k_lt_n   = k_q < n_q;
	assign sts.psq_lt_n = psq_q < n_q;
	assign sts.p_comp   = rd_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign prime_count = prime_count_q;

endmodule

/* rtl/prime_count_sieve.sv */
// Top level: prime count sieve, a stream-in / stream-out wrapper of controller and datapath.
//
// Usage:
//  - Slave stream s_axis carries one request per beat: tdata[14:0] is the limit n.
//    Limits above 16384 are treated as 16384.
//  - Master stream m_axis returns one beat per request: tdata[10:0] is the number
//    of primes p with 2 <= p < n.
//  - s_axis_tready is high only while no request is in work; one request at a time.
// Phases per request (n after saturation):
//  - clear pass over marks 0..n-1: one write per cycle
//  - sieve: a mark read for each candidate p with p*p < n plus one final test, one
//    write per marked multiple and one closing step per prime, one memory port pair
//  - count pass over 2..n-1: one read per cycle
// The result lands in an output register; the next request is accepted as soon
// as it is loaded, even while m_axis waits for tready. If the previous result is
// still unclaimed when a new one finishes, the block holds in its done state.
// Reset (arst_n low) returns the controller to idle and drops m_axis_tvalid; the
// mark memory is not cleared, each request clears what it reads.
`include "prime_count_sieve_macros.svh"

module prime_count_sieve
	import pcs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [14:0] limit, rest zero
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [10:0] prime_count, rest zero
);

	pcs_cmd_t          cmd;
	pcs_sts_t          sts;
	logic [CNT_W-1:0]  prime_count;

	pcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pcs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.limit       (s_axis_tdata[N_W-1:0]),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.prime_count (prime_count)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W-CNT_W){1'b0}}, prime_count};

	// a taken request keeps the input closed until its result is loaded
	`PCS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input open while request in work")
	// a finished count never overwrites an unclaimed result
	`PCS_ASSERT_NOW(a_no_overwrite, cmd.out_load, sts.out_free, "result loaded over pending beat")
	// mark writes stay below the limit of the request
	`PCS_ASSERT_NOW(a_write_in_range, cmd.clr_wr || cmd.mark_wr, sts.k_lt_n, "mark write beyond limit")
	// a loaded result shows up on the master side next cycle
	`PCS_ASSERT_NEXT(a_result_shown, cmd.out_load, m_axis_tvalid, "loaded result not presented")

endmodule
